[hdl/sa_pkg.sv]
// Shared types, widths, reset values and fixed tables of the spotlight attenuation block.
// Depends on nothing; every module of the block imports it.
package sa_pkg;

   // Coordinate and vector widths
   localparam int COORD_WIDTH = 24;
   localparam int DIFF_W      = COORD_WIDTH + 1;
   localparam int MAG_W       = COORD_WIDTH;
   localparam int SQ_W        = 2 * MAG_W;
   localparam int DSQ_W       = SQ_W + 2;
   localparam int SQREM_W     = DSQ_W + 1;
   localparam int ROOT_W      = DSQ_W / 2;
   localparam int AX_W        = 16;
   localparam int DP_W        = DIFF_W + AX_W;
   localparam int DOT_W       = DP_W + 2;
   localparam int DOTM_W      = DOT_W - 1;

   // Configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 48;
   localparam int AXIS_W      = 48;
   localparam int COEF_W      = 24;
   localparam int SHAPE_W     = 32;

   // Denominator and distance attenuation
   localparam int FRAC16      = 16;
   localparam int LIN_W       = COEF_W + ROOT_W;
   localparam int AQ_W        = DSQ_W - FRAC16 + COEF_W;
   localparam int LQ_W        = FRAC16 + COEF_W;
   localparam int QTERM_W     = 41;
   localparam logic [QTERM_W-1:0] QCAP = QTERM_W'(1) << (QTERM_W - 1);
   localparam int DEN_W       = 42;
   localparam int DREM_W      = DEN_W + 1;
   localparam int ATT_STEPS   = 33;
   localparam int ATT_W       = ATT_STEPS;

   // Cosine and spot factor
   localparam int COS_STEPS   = 15;
   localparam int CM_W        = COS_STEPS;
   localparam int COS_W       = 16;
   localparam logic [CM_W-1:0] ONE_Q14 = CM_W'(16384);
   localparam int LOG_DEPTH   = 256;
   localparam int LOG_BITS    = $clog2(LOG_DEPTH);
   localparam int LOG_W       = 16;
   localparam int SPOT_W      = 17;
   localparam logic [SPOT_W-1:0] ONE_Q16 = SPOT_W'(65536);
   localparam int SHIFT_W     = 4;
   localparam int NEG_W       = SHIFT_W + LOG_W;
   localparam int EXPO_W      = 16;
   localparam int PROD_W      = NEG_W + EXPO_W - 8;
   localparam int EXPQ_W      = PROD_W - FRAC16;
   localparam int SF_STAGES   = 4;
   localparam int SPOT_DLY    = ATT_STEPS + 1 - COS_STEPS - SF_STAGES;

   // Result
   localparam int OUT_W       = 24;
   localparam int VAL_W       = ATT_W + SPOT_W - FRAC16;
   localparam logic [OUT_W-1:0] OUT_MAX = '1;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   // Register reset values
   localparam logic [AXIS_W-1:0]  AXIS_RESET  = AXIS_W'(49152);
   localparam logic [COEF_W-1:0]  CONST_RESET = COEF_W'(65536);
   localparam logic [SHAPE_W-1:0] SHAPE_RESET = SHAPE_W'(14189);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LIGHT_X   = 3'd0,
      CSR_LIGHT_Y   = 3'd1,
      CSR_LIGHT_Z   = 3'd2,
      CSR_AXIS      = 3'd3,
      CSR_CONSTANT  = 3'd4,
      CSR_LINEAR    = 3'd5,
      CSR_QUADRATIC = 3'd6,
      CSR_SHAPE     = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] light_x;
      logic signed [COORD_WIDTH-1:0] light_y;
      logic signed [COORD_WIDTH-1:0] light_z;
      logic [AXIS_W-1:0]             axis_packed;
      logic [COEF_W-1:0]             att_constant;
      logic [COEF_W-1:0]             att_linear;
      logic [COEF_W-1:0]             att_quadratic;
      logic [SHAPE_W-1:0]            spot_shape;
   } sa_cfg_type;

   typedef struct packed {
      logic [DSQ_W-1:0]  dsq;
      logic              dot_neg;
      logic [DOTM_W-1:0] dot_mag;
   } sa_item_type;

   typedef logic [LOG_W-1:0]  log_tab_type [LOG_DEPTH];
   typedef logic [SPOT_W-1:0] exp_tab_type [LOG_DEPTH];

   function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
      logic [63:0] n;
      logic [63:0] res;
      logic [63:0] bt;
      n   = n_in;
      res = '0;
      bt  = 64'd1 << 62;
      while (bt > n) bt = bt >> 2;
      while (bt != 0) begin
         if (n >= res + bt) begin
            n   = n - res - bt;
            res = (res >> 1) + bt;
         end else begin
            res = res >> 1;
         end
         bt = bt >> 2;
      end
      return res;
   endfunction

   // floor(log2(1 + i/depth)) in Q.16 by repeated squaring
   function automatic log_tab_type build_log_tab();
      log_tab_type     tab;
      logic [63:0]     x;
      logic [LOG_W-1:0] r;
      for (int i = 0; i < LOG_DEPTH; i++) begin
         x = ((64'(LOG_DEPTH) + 64'(i)) << 30) / LOG_DEPTH;
         r = '0;
         for (int k = 0; k < 16; k++) begin
            x = (x * x) >> 30;
            r = {r[LOG_W-2:0], 1'b0};
            if (x >= (64'd2 << 30)) begin
               x    = x >> 1;
               r[0] = 1'b1;
            end
         end
         tab[i] = r;
      end
      return tab;
   endfunction

   // floor(2^(-j/depth)) in Q.16 from products of square-root constants
   function automatic exp_tab_type build_exp_tab();
      exp_tab_type tab;
      logic [63:0] c [17];
      logic [63:0] t;
      logic [63:0] p;
      c[0] = 64'd1 << 29;
      for (int k = 1; k <= 16; k++) c[k] = isqrt64(c[k-1] << 30);
      for (int i = 0; i < LOG_DEPTH; i++) begin
         t = (64'(i) << 16) / LOG_DEPTH;
         p = 64'd1 << 30;
         for (int k = 1; k <= 16; k++) begin
            if (t[16-k]) p = (p * c[k]) >> 30;
         end
         tab[i] = SPOT_W'(p >> 14);
      end
      return tab;
   endfunction

   localparam log_tab_type LOG_TAB = build_log_tab();
   localparam exp_tab_type EXP_TAB = build_exp_tab();

endpackage

[hdl/spotlight_attenuation.sv]
// Spotlight cone and distance attenuation, top level: configuration registers and the
// front end, queue and back end. Depends on sa_pkg, sa_front, sa_queue and sa_back.
//
// Usage:
//   req_*  carries one surface point (signed Q16.8 x, y, z). A transfer happens on a
//          rising edge with req_valid high and req_stall low.
//   rsp_*  carries one result per point, in order: attenuation (unsigned Q8.16),
//          inside_cone and saturated. A transfer happens with rsp_valid high and
//          rsp_stall low.
//   csr_*  writes one register per transfer (csr_valid and csr_ready high);
//          csr_ready is always high. Write only while no point is in flight.
// Throughput: one point per cycle, sustained, while rsp_stall stays low.
// Pipeline: the back end holds the 25-stage square root and the 33-stage attenuation
//   divider, which run one bit per stage.
// Stall: a stalled response holds the back end; the front end keeps taking points
//   until the four-entry queue between them fills, then raises req_stall.
// Reset (synchronous): clears all valid state and loads the register defaults
//   (unit constant attenuation, axis along -x, default cutoff).
module spotlight_attenuation (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [sa_pkg::COORD_WIDTH-1:0] req_point_x,
   input  logic signed [sa_pkg::COORD_WIDTH-1:0] req_point_y,
   input  logic signed [sa_pkg::COORD_WIDTH-1:0] req_point_z,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [sa_pkg::OUT_W-1:0]             rsp_attenuation,
   output logic                                 rsp_inside_cone,
   output logic                                 rsp_saturated,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [sa_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [sa_pkg::CSR_DATA_W-1:0]        csr_data
);
   import sa_pkg::*;

   sa_cfg_type  cfg_ff;
   logic        push;
   sa_item_type push_item;
   logic        queue_full;
   logic        pop;
   logic        head_valid;
   sa_item_type head;

   // the register file takes a write every cycle
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.light_x       <= '0;
         cfg_ff.light_y       <= '0;
         cfg_ff.light_z       <= '0;
         cfg_ff.axis_packed   <= AXIS_RESET;
         cfg_ff.att_constant  <= CONST_RESET;
         cfg_ff.att_linear    <= '0;
         cfg_ff.att_quadratic <= '0;
         cfg_ff.spot_shape    <= SHAPE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_LIGHT_X:   cfg_ff.light_x       <= $signed(csr_data[COORD_WIDTH-1:0]);
            CSR_LIGHT_Y:   cfg_ff.light_y       <= $signed(csr_data[COORD_WIDTH-1:0]);
            CSR_LIGHT_Z:   cfg_ff.light_z       <= $signed(csr_data[COORD_WIDTH-1:0]);
            CSR_AXIS:      cfg_ff.axis_packed   <= csr_data[AXIS_W-1:0];
            CSR_CONSTANT:  cfg_ff.att_constant  <= csr_data[COEF_W-1:0];
            CSR_LINEAR:    cfg_ff.att_linear    <= csr_data[COEF_W-1:0];
            CSR_QUADRATIC: cfg_ff.att_quadratic <= csr_data[COEF_W-1:0];
            CSR_SHAPE:     cfg_ff.spot_shape    <= csr_data[SHAPE_W-1:0];
         endcase
      end
   end

   // front: vector from the light, squared distance and dot with the axis
   sa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (req_valid),
      .in_stall   (req_stall),
      .point_x    (req_point_x),
      .point_y    (req_point_y),
      .point_z    (req_point_z),
      .push       (push),
      .push_item  (push_item),
      .queue_full (queue_full)
   );

   // decouple the two halves so each can stall on its own
   sa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   // back: root, divisions, spot factor and the response register
   sa_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .in_valid    (head_valid),
      .in_item     (head),
      .pop         (pop),
      .out_valid   (rsp_valid),
      .out_stall   (rsp_stall),
      .attenuation (rsp_attenuation),
      .inside_cone (rsp_inside_cone),
      .saturated   (rsp_saturated)
   );

endmodule

[hdl/sa_front.sv]
// Front end: registers the point, forms the vector from the light, squared length and dot.
// Depends on sa_pkg for widths, the configuration struct and the queue item struct.
module sa_front (
   input  logic                                clock,
   input  logic                                reset,
   input  sa_pkg::sa_cfg_type                  cfg,
   input  logic                                in_valid,
   output logic                                in_stall,
   input  logic signed [sa_pkg::COORD_WIDTH-1:0] point_x,
   input  logic signed [sa_pkg::COORD_WIDTH-1:0] point_y,
   input  logic signed [sa_pkg::COORD_WIDTH-1:0] point_z,
   output logic                                push,
   output sa_pkg::sa_item_type                 push_item,
   input  logic                                queue_full
);
   import sa_pkg::*;

   logic en;

   logic                          f0_valid_ff;
   logic signed [COORD_WIDTH-1:0] f0_pt_ff [3];
   logic                          f1_valid_ff;
   logic signed [DIFF_W-1:0]      f1_dv_ff [3];
   logic signed [DIFF_W-1:0]      f1_dv_in [3];
   logic                          f2_valid_ff;
   logic [SQ_W-1:0]               f2_sq_ff [3];
   logic [SQ_W-1:0]               f2_sq_in [3];
   logic signed [DP_W-1:0]        f2_dp_ff [3];
   logic signed [DP_W-1:0]        f2_dp_in [3];
   logic                          f3_valid_ff;
   sa_item_type                   f3_item_ff;
   sa_item_type                   f3_item_in;

   logic signed [COORD_WIDTH-1:0] light [3];
   logic signed [AX_W-1:0]        ax [3];
   logic [MAG_W-1:0]              mag [3];
   logic signed [DOT_W-1:0]       dot;

   // hold the whole front while the queue cannot take a transfer
   assign en       = !queue_full;
   assign in_stall = queue_full;
   assign push     = en && f3_valid_ff;
   assign push_item = f3_item_ff;

   assign light[0] = $signed(cfg.light_x);
   assign light[1] = $signed(cfg.light_y);
   assign light[2] = $signed(cfg.light_z);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ax[i]       = $signed(cfg.axis_packed[i*AX_W +: AX_W]);
         f1_dv_in[i] = DIFF_W'(f0_pt_ff[i]) - DIFF_W'(light[i]);
         mag[i]      = MAG_W'(f1_dv_ff[i][DIFF_W-1] ? -f1_dv_ff[i] : f1_dv_ff[i]);
         f2_sq_in[i] = mag[i] * mag[i];
         f2_dp_in[i] = f1_dv_ff[i] * ax[i];
      end
      dot = DOT_W'(f2_dp_ff[0]) + DOT_W'(f2_dp_ff[1]) + DOT_W'(f2_dp_ff[2]);
      f3_item_in.dsq     = DSQ_W'(f2_sq_ff[0]) + DSQ_W'(f2_sq_ff[1]) + DSQ_W'(f2_sq_ff[2]);
      f3_item_in.dot_neg = dot[DOT_W-1];
      f3_item_in.dot_mag = DOTM_W'(dot[DOT_W-1] ? -dot : dot);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f0_valid_ff <= 1'b0;
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
         f3_valid_ff <= 1'b0;
      end else if (en) begin
         f0_valid_ff <= in_valid;
         f1_valid_ff <= f0_valid_ff;
         f2_valid_ff <= f1_valid_ff;
         f3_valid_ff <= f2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f0_pt_ff[0] <= point_x;
         f0_pt_ff[1] <= point_y;
         f0_pt_ff[2] <= point_z;
         f1_dv_ff    <= f1_dv_in;
         f2_sq_ff    <= f2_sq_in;
         f2_dp_ff    <= f2_dp_in;
         f3_item_ff  <= f3_item_in;
      end
   end

endmodule

[hdl/sa_queue.sv]
// Short queue of front-end items between the front and back ends.
// Depends on sa_pkg for the item struct and queue depth.
module sa_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sa_pkg::sa_item_type push_item,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output sa_pkg::sa_item_type head
);
   import sa_pkg::*;

   sa_item_type       mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = mem[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + QCNT_W'(1);
      if (pop && !push) count_in = count_ff - QCNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         if (pop) rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem[wr_ptr_ff] <= push_item;
   end

endmodule

[hdl/sa_back.sv]
// Back end: square root, denominator, two pipelined dividers, spot factor and output register.
// Depends on sa_pkg for widths, structs and the log2 and exp2 tables.
module sa_back (
   input  logic                          clock,
   input  logic                          reset,
   input  sa_pkg::sa_cfg_type            cfg,
   input  logic                          in_valid,
   input  sa_pkg::sa_item_type           in_item,
   output logic                          pop,
   output logic                          out_valid,
   input  logic                          out_stall,
   output logic [sa_pkg::OUT_W-1:0]      attenuation,
   output logic                          inside_cone,
   output logic                          saturated
);
   import sa_pkg::*;

   logic en;

   // square root stages
   logic               sq_valid_ff [ROOT_W];
   logic [SQREM_W-1:0] sq_rem_ff   [ROOT_W];
   logic [ROOT_W-1:0]  sq_root_ff  [ROOT_W];
   sa_item_type        sq_item_ff  [ROOT_W];

   // product stage
   logic              p_valid_ff;
   logic              p_zero_ff;
   logic [ROOT_W-1:0] p_d_ff;
   logic [LIN_W-1:0]  p_lin_ff;
   logic [AQ_W-1:0]   p_aq_ff;
   logic [LQ_W-1:0]   p_lq_ff;
   logic              p_big_ff;
   logic              p_neg_ff;
   logic [DOTM_W-1:0] p_mag_ff;
   sa_item_type       sq_last;
   logic [ROOT_W-1:0] d_last;

   // denominator stage
   logic              q_valid_ff;
   logic              q_zero_ff;
   logic              q_den0_ff;
   logic [DEN_W-1:0]  q_den_ff;
   logic [AQ_W:0]     qsum;
   logic [QTERM_W-1:0] qterm;
   logic [DEN_W-1:0]  den_in;

   // attenuation divider stages
   logic              ad_valid_ff [ATT_STEPS];
   logic              ad_zero_ff  [ATT_STEPS];
   logic              ad_den0_ff  [ATT_STEPS];
   logic [DEN_W-1:0]  ad_den_ff   [ATT_STEPS];
   logic [DREM_W-1:0] ad_rem_ff   [ATT_STEPS];
   logic [ATT_W-1:0]  ad_quo_ff   [ATT_STEPS];

   // cosine divider stages
   logic [DOTM_W-1:0] cd_rem_ff [COS_STEPS];
   logic [ROOT_W-1:0] cd_d_ff   [COS_STEPS];
   logic [CM_W-1:0]   cd_quo_ff [COS_STEPS];
   logic              cd_big_ff [COS_STEPS];
   logic              cd_neg_ff [COS_STEPS];

   // spot factor stages
   logic [EXPO_W-1:0]   expo;
   logic [CM_W-1:0]     cm;
   logic signed [COS_W-1:0] cosv;
   logic [SHIFT_W-1:0]  pidx;
   logic [CM_W-1:0]     norm;
   logic                sf1_pos_ff;
   logic                sf1_out_ff;
   logic [SHIFT_W-1:0]  sf1_shift_ff;
   logic [LOG_BITS-1:0] sf1_idx_ff;
   logic [SHIFT_W-1:0]  sf1_shift_in;
   logic                sf2_pos_ff;
   logic                sf2_out_ff;
   logic [NEG_W-1:0]    sf2_neg_ff;
   logic                sf3_pos_ff;
   logic                sf3_out_ff;
   logic [PROD_W-1:0]   sf3_prod_ff;
   logic [NEG_W+EXPO_W-1:0] prod_full;
   logic                sf4_out_ff;
   logic [SPOT_W-1:0]   sf4_spot_ff;
   logic [SPOT_W-1:0]   spot_in;
   logic [EXPQ_W-1:0]   eq;
   logic [LOG_BITS-1:0] ej;
   logic [SPOT_W-1:0]   dl_spot_ff [SPOT_DLY];
   logic                dl_out_ff  [SPOT_DLY];

   // product and output stages
   logic              f_valid_ff;
   logic              f_zero_ff;
   logic              f_den0_ff;
   logic              f_out_ff;
   logic [VAL_W-1:0]  f_val_ff;
   logic [ATT_W+SPOT_W-1:0] val_full;
   logic              rsp_valid_ff;
   logic [OUT_W-1:0]  rsp_att_ff;
   logic              rsp_inside_ff;
   logic              rsp_sat_ff;
   logic [OUT_W-1:0]  rsp_att_in;
   logic              rsp_inside_in;
   logic              rsp_sat_in;

   // advance the whole back end when the output register is free or being taken
   assign en          = !rsp_valid_ff || !out_stall;
   assign pop         = en && in_valid;
   assign out_valid   = rsp_valid_ff;
   assign attenuation = rsp_att_ff;
   assign inside_cone = rsp_inside_ff;
   assign saturated   = rsp_sat_ff;
   assign expo        = cfg.spot_shape[SHAPE_W-1 -: EXPO_W];

   // one root bit per stage, most significant first
   for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
      localparam int B = ROOT_W - 1 - k;
      logic               valid_prev;
      logic [SQREM_W-1:0] rem_prev;
      logic [ROOT_W-1:0]  root_prev;
      sa_item_type        item_prev;
      logic [SQREM_W-1:0] trial;
      if (k == 0) begin : g_first
         assign valid_prev = in_valid;
         assign rem_prev   = SQREM_W'(in_item.dsq);
         assign root_prev  = '0;
         assign item_prev  = in_item;
      end else begin : g_next
         assign valid_prev = sq_valid_ff[k-1];
         assign rem_prev   = sq_rem_ff[k-1];
         assign root_prev  = sq_root_ff[k-1];
         assign item_prev  = sq_item_ff[k-1];
      end
      assign trial = (SQREM_W'(root_prev) << (B + 1)) + (SQREM_W'(1) << (2 * B));
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[k] <= 1'b0;
         end else if (en) begin
            sq_valid_ff[k] <= valid_prev;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            sq_item_ff[k] <= item_prev;
            if (rem_prev >= trial) begin
               sq_rem_ff[k]  <= rem_prev - trial;
               sq_root_ff[k] <= root_prev | (ROOT_W'(1) << B);
            end else begin
               sq_rem_ff[k]  <= rem_prev;
               sq_root_ff[k] <= root_prev;
            end
         end
      end
   end

   assign sq_last = sq_item_ff[ROOT_W-1];
   assign d_last  = sq_root_ff[ROOT_W-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (en) begin
         p_valid_ff <= sq_valid_ff[ROOT_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_zero_ff <= (sq_last.dsq == '0);
         p_d_ff    <= d_last;
         p_lin_ff  <= LIN_W'(cfg.att_linear) * LIN_W'(d_last);
         p_aq_ff   <= AQ_W'(sq_last.dsq[DSQ_W-1:FRAC16]) * AQ_W'(cfg.att_quadratic);
         p_lq_ff   <= LQ_W'(sq_last.dsq[FRAC16-1:0]) * LQ_W'(cfg.att_quadratic);
         p_big_ff  <= (sq_last.dot_mag >= (DOTM_W'(d_last) << COS_STEPS));
         p_neg_ff  <= sq_last.dot_neg;
         p_mag_ff  <= sq_last.dot_mag;
      end
   end

   // denominator: constant + linear*d + capped quadratic term
   always_comb begin
      qsum   = (AQ_W+1)'(p_aq_ff) + (AQ_W+1)'(p_lq_ff >> FRAC16);
      qterm  = (qsum > (AQ_W+1)'(QCAP)) ? QCAP : QTERM_W'(qsum);
      den_in = DEN_W'(cfg.att_constant) + DEN_W'(p_lin_ff >> 8) + DEN_W'(qterm);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_valid_ff <= 1'b0;
      end else if (en) begin
         q_valid_ff <= p_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_zero_ff <= p_zero_ff;
         q_den_ff  <= den_in;
         q_den0_ff <= (den_in == '0);
      end
   end

   // 2^32 / denominator, one quotient bit per stage
   for (genvar j = 0; j < ATT_STEPS; j++) begin : g_adiv
      logic              valid_prev;
      logic              zero_prev;
      logic              den0_prev;
      logic [DEN_W-1:0]  den_prev;
      logic [DREM_W-1:0] rem_prev;
      logic [ATT_W-1:0]  quo_prev;
      logic [DREM_W-1:0] shifted;
      if (j == 0) begin : g_first
         assign valid_prev = q_valid_ff;
         assign zero_prev  = q_zero_ff;
         assign den0_prev  = q_den0_ff;
         assign den_prev   = q_den_ff;
         assign rem_prev   = '0;
         assign quo_prev   = '0;
      end else begin : g_next
         assign valid_prev = ad_valid_ff[j-1];
         assign zero_prev  = ad_zero_ff[j-1];
         assign den0_prev  = ad_den0_ff[j-1];
         assign den_prev   = ad_den_ff[j-1];
         assign rem_prev   = ad_rem_ff[j-1];
         assign quo_prev   = ad_quo_ff[j-1];
      end
      // the dividend has its only set bit at the top
      assign shifted = {rem_prev[DREM_W-2:0], (j == 0) ? 1'b1 : 1'b0};
      always_ff @(posedge clock) begin
         if (reset) begin
            ad_valid_ff[j] <= 1'b0;
         end else if (en) begin
            ad_valid_ff[j] <= valid_prev;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            ad_zero_ff[j] <= zero_prev;
            ad_den0_ff[j] <= den0_prev;
            ad_den_ff[j]  <= den_prev;
            if (shifted >= DREM_W'(den_prev)) begin
               ad_rem_ff[j] <= shifted - DREM_W'(den_prev);
               ad_quo_ff[j] <= {quo_prev[ATT_W-2:0], 1'b1};
            end else begin
               ad_rem_ff[j] <= shifted;
               ad_quo_ff[j] <= {quo_prev[ATT_W-2:0], 1'b0};
            end
         end
      end
   end

   // |dot| / d below the clamp, one quotient bit per stage
   for (genvar i = 0; i < COS_STEPS; i++) begin : g_cdiv
      localparam int B = COS_STEPS - 1 - i;
      logic [DOTM_W-1:0] rem_prev;
      logic [ROOT_W-1:0] d_prev;
      logic [CM_W-1:0]   quo_prev;
      logic              big_prev;
      logic              neg_prev;
      logic [DOTM_W-1:0] trial;
      if (i == 0) begin : g_first
         assign rem_prev = p_mag_ff;
         assign d_prev   = p_d_ff;
         assign quo_prev = '0;
         assign big_prev = p_big_ff;
         assign neg_prev = p_neg_ff;
      end else begin : g_next
         assign rem_prev = cd_rem_ff[i-1];
         assign d_prev   = cd_d_ff[i-1];
         assign quo_prev = cd_quo_ff[i-1];
         assign big_prev = cd_big_ff[i-1];
         assign neg_prev = cd_neg_ff[i-1];
      end
      assign trial = DOTM_W'(d_prev) << B;
      always_ff @(posedge clock) begin
         if (en) begin
            cd_d_ff[i]   <= d_prev;
            cd_big_ff[i] <= big_prev;
            cd_neg_ff[i] <= neg_prev;
            if (rem_prev >= trial) begin
               cd_rem_ff[i] <= rem_prev - trial;
               cd_quo_ff[i] <= quo_prev | (CM_W'(1) << B);
            end else begin
               cd_rem_ff[i] <= rem_prev;
               cd_quo_ff[i] <= quo_prev;
            end
         end
      end
   end

   // clamp the cosine, test the cone and normalize for the log table
   always_comb begin
      if (cd_big_ff[COS_STEPS-1] || (cd_quo_ff[COS_STEPS-1] > ONE_Q14)) begin
         cm = ONE_Q14;
      end else begin
         cm = cd_quo_ff[COS_STEPS-1];
      end
      cosv = cd_neg_ff[COS_STEPS-1] ? -$signed(COS_W'(cm)) : $signed(COS_W'(cm));
      pidx = '0;
      for (int b = 0; b < CM_W; b++) begin
         if (cm[b]) pidx = SHIFT_W'(b);
      end
      sf1_shift_in = SHIFT_W'(CM_W - 1) - pidx;
      norm = cm << sf1_shift_in;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sf1_pos_ff   <= !cd_neg_ff[COS_STEPS-1] && (cm != '0);
         sf1_out_ff   <= (cosv < $signed(cfg.spot_shape[COS_W-1:0]));
         sf1_shift_ff <= sf1_shift_in;
         sf1_idx_ff   <= norm[CM_W-2 -: LOG_BITS];
      end
   end

   // spot factor: exp2(-exponent * (shift - log2(mantissa)))
   always_comb begin
      prod_full = NEG_W'(sf2_neg_ff) * (NEG_W+EXPO_W)'(expo);
      eq        = sf3_prod_ff[PROD_W-1:FRAC16];
      ej        = sf3_prod_ff[FRAC16-1 -: LOG_BITS];
      if (sf3_pos_ff) begin
         spot_in = (eq < EXPQ_W'(SPOT_W)) ? (EXP_TAB[ej] >> eq) : '0;
      end else begin
         spot_in = (expo == '0) ? ONE_Q16 : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sf2_pos_ff  <= sf1_pos_ff;
         sf2_out_ff  <= sf1_out_ff;
         sf2_neg_ff  <= {sf1_shift_ff, {LOG_W{1'b0}}} - NEG_W'(LOG_TAB[sf1_idx_ff]);
         sf3_pos_ff  <= sf2_pos_ff;
         sf3_out_ff  <= sf2_out_ff;
         sf3_prod_ff <= prod_full[NEG_W+EXPO_W-1:8];
         sf4_out_ff  <= sf3_out_ff;
         sf4_spot_ff <= spot_in;
      end
   end

   // line up the spot factor with the end of the attenuation divider
   for (genvar s = 0; s < SPOT_DLY; s++) begin : g_dly
      always_ff @(posedge clock) begin
         if (en) begin
            if (s == 0) begin
               dl_spot_ff[s] <= sf4_spot_ff;
               dl_out_ff[s]  <= sf4_out_ff;
            end else begin
               dl_spot_ff[s] <= dl_spot_ff[s-1];
               dl_out_ff[s]  <= dl_out_ff[s-1];
            end
         end
      end
   end

   assign val_full = (ATT_W+SPOT_W)'(ad_quo_ff[ATT_STEPS-1])
                   * (ATT_W+SPOT_W)'(dl_spot_ff[SPOT_DLY-1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (en) begin
         f_valid_ff <= ad_valid_ff[ATT_STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_zero_ff <= ad_zero_ff[ATT_STEPS-1];
         f_den0_ff <= ad_den0_ff[ATT_STEPS-1];
         f_out_ff  <= dl_out_ff[SPOT_DLY-1];
         f_val_ff  <= val_full[ATT_W+SPOT_W-1:FRAC16];
      end
   end

   // special cases in order: zero distance, outside cone, zero denominator or overflow
   always_comb begin
      priority if (f_zero_ff) begin
         rsp_att_in    = OUT_MAX;
         rsp_inside_in = 1'b1;
         rsp_sat_in    = 1'b1;
      end else if (f_out_ff) begin
         rsp_att_in    = '0;
         rsp_inside_in = 1'b0;
         rsp_sat_in    = 1'b0;
      end else if (f_den0_ff || (f_val_ff > VAL_W'(OUT_MAX))) begin
         rsp_att_in    = OUT_MAX;
         rsp_inside_in = 1'b1;
         rsp_sat_in    = 1'b1;
      end else begin
         rsp_att_in    = OUT_W'(f_val_ff);
         rsp_inside_in = 1'b1;
         rsp_sat_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= f_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_att_ff    <= rsp_att_in;
         rsp_inside_ff <= rsp_inside_in;
         rsp_sat_ff    <= rsp_sat_in;
      end
   end

endmodule
